FILE: rtl/lss_pkg.sv
// Shared types and constants for the lap and sector split timer.
// Holds the command codes, the field widths and the controller/datapath handshake structs.
// No dependencies.
package lss_pkg;

    localparam int TIME_W     = 32;
    localparam int SUM_W      = 40;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int SECNUM_W   = 4;

    localparam int S_TDATA_W  = TIME_W;
    localparam int S_TUSER_W  = CMD_W;
    localparam int OUT_BITS   = 3 * TIME_W + SECNUM_W + SUM_W;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W  = 2;

    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SECTOR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LAP     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS   = 2'd1;

    // Radix-4 restoring divider: two quotient bits per cycle.
    localparam int DIV_STEPS  = 2;
    localparam int DIV_CYCLES = SUM_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic capture;
        logic exec;
        logic post;
        logic div_start;
        logic load_out;
    } lss_cmd_t;

    typedef struct packed {
        logic div_done;
    } lss_status_t;

endpackage

FILE: rtl/lss_div.sv
// Iterative unsigned divider for the average lap time, two quotient bits per cycle.
// Depends on lss_pkg for the dividend width and the iteration count.
module lss_div
    import lss_pkg::*;
#(
    parameter int DIVISOR_W = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SUM_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [SUM_W-1:0]     quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     shift_reg;
    logic [SUM_W-1:0]     shift_next;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W-1:0] dvs_reg;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    always_comb begin
        logic [DIVISOR_W:0] trial;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial      = {rem_next, shift_next[SUM_W-1]};
            shift_next = {shift_next[SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                trial         = trial - {1'b0, dvs_reg};
                shift_next[0] = 1'b1;
            end
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_CYCLES - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= divisor;
        end else if (busy_reg) begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");

endmodule

FILE: rtl/lss_dp.sv
// Datapath of the split timer: time registers, sector history ring, running sum, output word.
// Depends on lss_pkg and instantiates lss_div for the average.
module lss_dp
    import lss_pkg::*;
#(
    parameter int MAX_SECTORS = 16,
    parameter int MAX_SLOTS   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lss_cmd_t              cmd,
    output lss_status_t           status,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser
);

    localparam int DEPTH  = MAX_SECTORS * MAX_SLOTS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEC_W  = $clog2(MAX_SECTORS + 1);
    localparam int SP_W   = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
    localparam int SL_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PAD_W  = M_TDATA_W - OUT_BITS;
    localparam int EXT_W  = SUM_W - TIME_W;

    logic [TIME_W-1:0]   mem [DEPTH];

    logic [CMD_W-1:0]    cmd_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [SEC_W-1:0]    spl_reg;
    logic [SLOT_W-1:0]   slots_reg;
    logic [AW-1:0]       widx_reg;
    logic [SP_W-1:0]     sector_pos_reg;
    logic [SL_W-1:0]     slot_pos_reg;
    logic                full_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [TIME_W-1:0]   lap_count_reg;
    logic [TIME_W-1:0]   timer_start_reg;
    logic [TIME_W-1:0]   lap_start_reg;
    logic [TIME_W-1:0]   sector_start_reg;
    logic [TIME_W-1:0]   old_reg;
    logic [TIME_W-1:0]   elapsed_reg;
    logic [TIME_W-1:0]   elapsed_next;
    logic                wrong_reg;
    logic                wrong_next;
    logic [TIME_W-1:0]   since_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic                cfg_hit;
    logic [SEC_W-1:0]    spl_wr;
    logic [SLOT_W-1:0]   slots_wr;
    logic                sector_last;
    logic                slot_last;
    logic [SLOT_W-1:0]   laps_n;
    logic                avg_valid;
    logic [SUM_W-1:0]    quotient;
    logic [SUM_W-1:0]    avg;

    // Register writes clamp 0 up to 1 and anything above the maximum down to it.
    assign cfg_hit  = cfg_we && (cfg_index == REG_SECTORS || cfg_index == REG_SLOTS);
    assign spl_wr   = (cfg_data == '0) ? SEC_W'(1) :
                      ((32'(cfg_data) > MAX_SECTORS) ? SEC_W'(MAX_SECTORS) : SEC_W'(cfg_data));
    assign slots_wr = (cfg_data == '0) ? SLOT_W'(1) :
                      ((32'(cfg_data) > MAX_SLOTS) ? SLOT_W'(MAX_SLOTS) : SLOT_W'(cfg_data));

    assign sector_last = (SEC_W'(sector_pos_reg) + SEC_W'(1)) == spl_reg;
    assign slot_last   = (SLOT_W'(slot_pos_reg) + SLOT_W'(1)) == slots_reg;

    always_comb begin
        case (cmd_reg)
            CMD_RESTART: elapsed_next = '0;
            CMD_SECTOR:  elapsed_next = now_reg - sector_start_reg;
            CMD_LAP:     elapsed_next = sector_start_reg - lap_start_reg;
            default:     elapsed_next = now_reg - lap_start_reg;
        endcase
        wrong_next = (cmd_reg == CMD_LAP) && (sector_pos_reg != '0);
    end

    // The ring is written in order from entry zero, so an entry holds a live
    // sector time exactly when the ring has wrapped once since it was cleared.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spl_reg          <= SEC_W'(1);
            slots_reg        <= SLOT_W'(1);
            widx_reg         <= '0;
            sector_pos_reg   <= '0;
            slot_pos_reg     <= '0;
            full_reg         <= 1'b0;
            sum_reg          <= '0;
            lap_count_reg    <= '0;
            timer_start_reg  <= '0;
            lap_start_reg    <= '0;
            sector_start_reg <= '0;
        end else if (cfg_hit) begin
            if (cfg_index == REG_SECTORS) begin
                spl_reg <= spl_wr;
            end else begin
                slots_reg <= slots_wr;
            end
            widx_reg       <= '0;
            sector_pos_reg <= '0;
            slot_pos_reg   <= '0;
            full_reg       <= 1'b0;
            sum_reg        <= '0;
        end else if (cmd.exec) begin
            case (cmd_reg)
                CMD_RESTART: begin
                    widx_reg         <= '0;
                    sector_pos_reg   <= '0;
                    slot_pos_reg     <= '0;
                    full_reg         <= 1'b0;
                    sum_reg          <= '0;
                    lap_count_reg    <= '0;
                    timer_start_reg  <= now_reg;
                    lap_start_reg    <= now_reg;
                    sector_start_reg <= now_reg;
                end
                CMD_SECTOR: begin
                    if (full_reg) begin
                        sum_reg <= sum_reg - {{EXT_W{1'b0}}, old_reg};
                    end
                    sector_start_reg <= now_reg;
                    if (sector_last) begin
                        sector_pos_reg <= '0;
                        if (slot_last) begin
                            slot_pos_reg <= '0;
                            widx_reg     <= '0;
                            full_reg     <= 1'b1;
                        end else begin
                            slot_pos_reg <= slot_pos_reg + SL_W'(1);
                            widx_reg     <= widx_reg + AW'(1);
                        end
                    end else begin
                        sector_pos_reg <= sector_pos_reg + SP_W'(1);
                        widx_reg       <= widx_reg + AW'(1);
                    end
                end
                CMD_LAP: begin
                    if (lap_count_reg != '1) begin
                        lap_count_reg <= lap_count_reg + TIME_W'(1);
                    end
                    lap_start_reg <= sector_start_reg;
                end
                default: begin
                end
            endcase
        end else if (cmd.post && cmd_reg == CMD_SECTOR) begin
            sum_reg <= sum_reg + {{EXT_W{1'b0}}, elapsed_reg};
        end
    end

    always_ff @(posedge aclk) begin
        old_reg <= mem[widx_reg];
        if (cmd.exec && cmd_reg == CMD_SECTOR) begin
            mem[widx_reg] <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            now_reg <= s_tdata;
            cmd_reg <= s_tuser;
        end
        if (cmd.exec) begin
            elapsed_reg <= elapsed_next;
            wrong_reg   <= wrong_next;
        end
        if (cmd.post) begin
            since_reg <= now_reg - timer_start_reg;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, avg, SECNUM_W'(sector_pos_reg), lap_count_reg,
                            since_reg, elapsed_reg};
            m_tuser_reg <= {wrong_reg, avg_valid};
        end
    end

    assign laps_n    = (lap_count_reg < TIME_W'(slots_reg)) ? SLOT_W'(lap_count_reg) : slots_reg;
    assign avg_valid = lap_count_reg != '0;
    assign avg       = avg_valid ? quotient : '0;

    lss_div #(
        .DIVISOR_W (SLOT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (laps_n),
        .done     (status.div_done),
        .quotient (quotient)
    );

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    a_sector_in_lap: assert property (@(posedge aclk) disable iff (!aresetn)
        SEC_W'(sector_pos_reg) < spl_reg)
        else $error("sector position beyond sectors per lap");

    a_ring_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (widx_reg == '0) == (sector_pos_reg == '0 && slot_pos_reg == '0))
        else $error("ring index out of step with sector and slot position");

endmodule

FILE: rtl/lss_ctrl.sv
// Controller of the split timer: sequences capture, update, sum fix-up, divide and output load.
// Depends on lss_pkg for the command and status structs.
module lss_ctrl
    import lss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output lss_cmd_t    cmd,
    input  lss_status_t status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_POST   = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DWAIT  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd.capture   = accept;
        cmd.exec      = (state_reg == ST_EXEC);
        cmd.post      = (state_reg == ST_POST);
        cmd.div_start = (state_reg == ST_DSTART);
        cmd.load_out  = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_POST;
            ST_POST:   state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:  if (status.div_done) state_next = ST_OUT;
            ST_OUT:    if (cmd.load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // The output word stays until taken; a new result only loads into an empty or draining slot.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(m_valid_reg && !m_tready))
        else $error("result loaded over a word not yet taken");

    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> cmd.exec)
        else $error("accepted word not processed");

    a_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> state_reg == ST_DWAIT)
        else $error("divider finished outside the wait state");

endmodule

FILE: rtl/lap_sector_split_timer.sv
// Top level of the lap and sector split timer.
// Depends on lss_pkg; instantiates lss_ctrl and lss_dp (which holds lss_div).
//
// Each input word is a command (restart, sector split, lap, query) and a timestamp in ticks,
// and it produces exactly one result word. Words are handled one at a time: after acceptance
// a word passes the update, sum fix-up and divider start states, then waits on the radix-4
// divider that forms the average lap time from the 40-bit history sum; the result then goes
// into the output register. The next word is taken while a finished result still waits on
// the output side. The sector history is a ring of MAX_SECTORS * MAX_SLOTS entries filled in
// order from the first entry, so it needs no clearing after reset or after a register write.
// Register writes are expected only while the block is idle.
module lap_sector_split_timer
    import lss_pkg::*;
#(
    parameter int MAX_SECTORS = 16,
    parameter int MAX_SLOTS   = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // now[31:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // command[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // elapsed[31:0], since_start[63:32], laps_done[95:64], sector_number[99:96],
    // average_lap[139:100], zero fill[143:140]
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser,   // average_valid[0], wrong_sector[1]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lss_cmd_t    cmd;
    lss_status_t status;

    lss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    lss_dp #(
        .MAX_SECTORS (MAX_SECTORS),
        .MAX_SLOTS   (MAX_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for lap_sector_split_timer: random and directed split events,
// register writes between phases, and a scoreboard that predicts every result word.
// Depends on lss_pkg and the lap_sector_split_timer RTL.
`timescale 1ns / 100ps

module tb;
    import lss_pkg::*;

    localparam int MAX_SECTORS   = 16;
    localparam int MAX_SLOTS     = 16;
    localparam int RING_DEPTH    = MAX_SECTORS * MAX_SLOTS;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 200;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 34;
    localparam int MAX_REPORTS   = 50;
    localparam longint RUN_LIMIT_NS = 10_000_000;

    // Indexes outside the register list; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 2'd3;

    localparam int SINCE_LSB  = TIME_W;
    localparam int LAPS_LSB   = 2 * TIME_W;
    localparam int SECNUM_LSB = 3 * TIME_W;
    localparam int AVG_LSB    = 3 * TIME_W + SECNUM_W;
    localparam int USER_AVG_VALID = 0;
    localparam int USER_WRONG     = 1;

    typedef struct packed {
        logic [TIME_W-1:0]   elapsed;
        logic [TIME_W-1:0]   since_start;
        logic [TIME_W-1:0]   laps_done;
        logic [SECNUM_W-1:0] sector_number;
        logic [SUM_W-1:0]    average_lap;
        logic                average_valid;
        logic                wrong_sector;
    } split_result_t;

    class split_scoreboard;
        int unsigned         sectors;
        int unsigned         slots;
        bit [TIME_W-1:0]     history [RING_DEPTH];
        bit                  history_valid [RING_DEPTH];
        bit [SUM_W-1:0]      history_sum;
        int unsigned         write_index;
        bit [TIME_W-1:0]     lap_count;
        bit [TIME_W-1:0]     timer_start;
        bit [TIME_W-1:0]     lap_start;
        bit [TIME_W-1:0]     sector_start;
        split_result_t       expected_q[$];
        int                  errors;
        int                  reports;

        function new();
            sectors = 1;
            slots = 1;
            foreach (history[i]) history[i] = '0;
            clear_history();
            lap_count = '0;
            timer_start = '0;
            lap_start = '0;
            sector_start = '0;
            errors = 0;
            reports = 0;
        endfunction

        function void clear_history();
            foreach (history_valid[i]) history_valid[i] = 1'b0;
            history_sum = '0;
            write_index = 0;
        endfunction

        function int unsigned clamp_reg(logic [CFG_DATA_W-1:0] v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return 32'(v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SECTORS: begin
                    sectors = clamp_reg(val, MAX_SECTORS);
                    clear_history();
                end
                REG_SLOTS: begin
                    slots = clamp_reg(val, MAX_SLOTS);
                    clear_history();
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Works out the result word for one accepted event and queues it.
        function void note_event(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now);
            split_result_t r;
            int unsigned   ring_len;
            int unsigned   idx;
            int unsigned   n;
            bit [63:0]     quotient;
            r = '0;
            case (cmd)
                CMD_RESTART: begin
                    clear_history();
                    lap_count = '0;
                    timer_start = now;
                    lap_start = now;
                    sector_start = now;
                end
                CMD_SECTOR: begin
                    ring_len = sectors * slots;
                    idx = (write_index < ring_len) ? write_index : 0;
                    r.elapsed = now - sector_start;
                    if (history_valid[idx]) history_sum = history_sum - SUM_W'(history[idx]);
                    history[idx] = r.elapsed;
                    history_valid[idx] = 1'b1;
                    history_sum = history_sum + SUM_W'(r.elapsed);
                    idx++;
                    write_index = (idx >= ring_len) ? 0 : idx;
                    sector_start = sector_start + r.elapsed;
                end
                CMD_LAP: begin
                    r.wrong_sector = (write_index % sectors) != 0;
                    if (lap_count != '1) lap_count++;
                    r.elapsed = sector_start - lap_start;
                    lap_start = sector_start;
                end
                default: begin
                    r.elapsed = now - lap_start;
                end
            endcase
            if (lap_count != 0) begin
                n = (lap_count < slots) ? lap_count : slots;
                quotient = 64'(history_sum) / 64'(n);
                r.average_lap = quotient[SUM_W-1:0];
            end
            r.since_start = now - timer_start;
            r.laps_done = lap_count;
            r.sector_number = SECNUM_W'(write_index % sectors);
            r.average_valid = lap_count != 0;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void compare(string name, logic [SUM_W-1:0] exp_v, logic [SUM_W-1:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
                end
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            split_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: result word with nothing expected, data %h", $time, data);
                end
                return;
            end
            e = expected_q.pop_front();
            compare("elapsed", SUM_W'(e.elapsed), SUM_W'(data[0 +: TIME_W]));
            compare("since_start", SUM_W'(e.since_start), SUM_W'(data[SINCE_LSB +: TIME_W]));
            compare("laps_done", SUM_W'(e.laps_done), SUM_W'(data[LAPS_LSB +: TIME_W]));
            compare("sector_number", SUM_W'(e.sector_number),
                    SUM_W'(data[SECNUM_LSB +: SECNUM_W]));
            compare("average_lap", e.average_lap, data[AVG_LSB +: SUM_W]);
            compare("zero fill", '0, SUM_W'(data[M_TDATA_W-1:OUT_BITS]));
            compare("average_valid", SUM_W'(e.average_valid), SUM_W'(user[USER_AVG_VALID]));
            compare("wrong_sector", SUM_W'(e.wrong_sector), SUM_W'(user[USER_WRONG]));
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    split_scoreboard sb;
    bit              offering;
    bit              hold_off_req;
    int              burst_left;
    logic [TIME_W-1:0] tick_now;
    logic [CMD_W-1:0]  cmd_pool [4] = '{CMD_RESTART, CMD_SECTOR, CMD_LAP, CMD_QUERY};

    lap_sector_split_timer #(
        .MAX_SECTORS(MAX_SECTORS),
        .MAX_SLOTS  (MAX_SLOTS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Receiver: stalls on a pattern that changes at random intervals, and once in a
    // while holds off for a long stretch so that the block backs up into its input.
    initial begin : result_sink
        int mode;
        int stretch;
        int cycle;
        stretch = 0;
        cycle = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (stretch == 0) begin
                mode = $urandom_range(0, 3);
                stretch = $urandom_range(20, 80);
            end
            stretch--;
            cycle++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (cycle % 8 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    function automatic logic [TIME_W-1:0] next_time();
        if ($urandom_range(0, 7) == 0) tick_now = tick_now + $urandom;
        else tick_now = tick_now + $urandom_range(1, 5000);
        return tick_now;
    endfunction

    // Offers one word; the sender works in bursts with random gaps between them.
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 6);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                if (offering) begin
                    s_tvalid <= 1'b0;
                    offering = 1'b0;
                end
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= now;
        s_tuser <= cmd;
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_event(cmd, now);
    endtask

    task automatic wait_idle();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_layout(logic [CFG_DATA_W-1:0] sec_val,
                                  logic [CFG_DATA_W-1:0] slot_val, bit poke_unused);
        logic [CFG_IDX_W-1:0]  spare_idx;
        logic [CFG_DATA_W-1:0] spare_val;
        cfg_we <= 1'b1;
        cfg_index <= REG_SECTORS;
        cfg_data <= sec_val;
        @(posedge aclk);
        sb.write_reg(REG_SECTORS, sec_val);
        cfg_index <= REG_SLOTS;
        cfg_data <= slot_val;
        @(posedge aclk);
        sb.write_reg(REG_SLOTS, slot_val);
        if (poke_unused) begin
            spare_idx = ($urandom_range(0, 1) == 0) ? REG_NONE_LO : REG_NONE_HI;
            spare_val = CFG_DATA_W'($urandom);
            cfg_index <= spare_idx;
            cfg_data <= spare_val;
            @(posedge aclk);
            sb.write_reg(spare_idx, spare_val);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(int unsigned hi);
        case ($urandom_range(0, 4))
            0: return CFG_DATA_W'(1);
            1: return CFG_DATA_W'(hi);
            2: return CFG_DATA_W'(0);
            3: return CFG_DATA_W'($urandom_range(hi + 1, 31));
            default: return CFG_DATA_W'($urandom_range(1, hi));
        endcase
    endfunction

    // Mostly well-formed laps (a sector word per sector, then a lap word) with random
    // timing, mixed with queries, miscounted laps and random noise words.
    task automatic run_phase(int budget);
        int left;
        int count;
        left = budget;
        if ($urandom_range(0, 3) != 0) begin
            send_word(CMD_RESTART, next_time());
            left--;
        end
        while (left > 0) begin
            if ($urandom_range(0, 4) != 0) begin
                count = sb.sectors;
                if ($urandom_range(0, 7) == 0) count = count + 1;
                else if ($urandom_range(0, 7) == 0) count = count - 1;
                for (int i = 0; i < count && left > 0; i++) begin
                    if ($urandom_range(0, 9) == 0 && left > 1) begin
                        send_word(CMD_QUERY, next_time());
                        left--;
                    end
                    send_word(CMD_SECTOR, next_time());
                    left--;
                end
                if (left > 0) begin
                    send_word(CMD_LAP, next_time());
                    left--;
                end
            end else begin
                send_word(cmd_pool[$urandom_range(0, 3)],
                          ($urandom_range(0, 2) == 0) ? $urandom : next_time());
                left--;
            end
        end
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] sec_val;
        logic [CFG_DATA_W-1:0] slot_val;
        sb = new();
        offering = 1'b0;
        hold_off_req = 1'b0;
        burst_left = 0;
        tick_now = $urandom;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_QUERY;
        cfg_we = 1'b0;
        cfg_index = REG_SECTORS;
        cfg_data = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset layout, no restart yet: all start times are zero.
        send_word(CMD_QUERY, 32'h0000_0005);
        send_word(CMD_SECTOR, 32'h0000_0010);
        send_word(CMD_LAP, 32'h0000_0020);
        send_word(CMD_QUERY, 32'hFFFF_FFFF);
        wait_idle();

        // Three sectors, two laps of history; times wrap through zero.
        program_layout(5'd3, 5'd2, 1'b0);
        send_word(CMD_RESTART, 32'hFFFF_FFF0);
        send_word(CMD_QUERY, 32'hFFFF_FFF8);
        send_word(CMD_SECTOR, 32'h0000_0008);
        send_word(CMD_SECTOR, 32'h0000_0100);
        send_word(CMD_LAP, 32'h0000_0180);
        send_word(CMD_SECTOR, 32'h0000_0200);
        send_word(CMD_LAP, 32'h0000_0280);
        send_word(CMD_SECTOR, 32'h7FFF_FFFF);
        send_word(CMD_SECTOR, 32'h8000_0000);
        send_word(CMD_SECTOR, 32'hFFFF_FFFF);
        send_word(CMD_LAP, 32'h0000_0000);
        send_word(CMD_SECTOR, 32'hAAAA_AAAA);
        send_word(CMD_LAP, 32'hAAAA_AAAB);
        send_word(CMD_RESTART, 32'h5555_5555);
        send_word(CMD_LAP, 32'h5555_6000);
        send_word(CMD_QUERY, 32'h5555_7000);
        wait_idle();

        // Out-of-range register values clamp; spare indexes must leave the history alone.
        program_layout(5'd0, 5'd31, 1'b1);
        send_word(CMD_SECTOR, 32'h5555_8000);
        send_word(CMD_LAP, 32'h5555_9000);
        send_word(CMD_QUERY, 32'h5555_A000);
        wait_idle();
        program_layout(5'd17, 5'd0, 1'b1);
        send_word(CMD_SECTOR, 32'h5555_B000);
        send_word(CMD_LAP, 32'h5555_C000);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    sec_val = CFG_DATA_W'(MAX_SECTORS);
                    slot_val = CFG_DATA_W'(MAX_SLOTS);
                end
                1: begin
                    sec_val = CFG_DATA_W'(1);
                    slot_val = CFG_DATA_W'(1);
                end
                2: begin
                    sec_val = CFG_DATA_W'(MAX_SECTORS);
                    slot_val = CFG_DATA_W'(1);
                end
                3: begin
                    sec_val = CFG_DATA_W'(1);
                    slot_val = CFG_DATA_W'(MAX_SLOTS);
                end
                default: begin
                    sec_val = pick_reg_value(MAX_SECTORS);
                    slot_val = pick_reg_value(MAX_SLOTS);
                end
            endcase
            program_layout(sec_val, slot_val, $urandom_range(0, 3) == 0);
            if (p == 3 || p == 8) hold_off_req = 1'b1;
            run_phase(PHASE_WORDS);
        end
        wait_idle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/lss_pkg.sv
rtl/lss_div.sv
rtl/lss_dp.sv
rtl/lss_ctrl.sv
rtl/lap_sector_split_timer.sv
tb/tb.sv
